// File: hw/rtl/rssd_pkg.sv
// ----------------------------------------------------------------------------
// rssd_pkg: shared types and constants for the running sum of squared deviations
// Operation and status codes, sequencer states and the result records of the
// shared multiplier and divider.
// ----------------------------------------------------------------------------
package rssd_pkg;

  localparam int RSSD_COUNT_WIDTH     = 32;
  localparam int RSSD_COUNT_WIDTH_MAX = 48;  // widest count the design supports
  localparam int RSSD_DIV_IDX_W       = 7;   // step index over a 128-bit dividend

  localparam logic [63:0] S64_MAX = {1'b0, {63{1'b1}}};
  localparam logic [63:0] S64_MIN = {1'b1, {63{1'b0}}};

  typedef enum logic [1:0] {
    FUNC_ADD   = 2'd0,
    FUNC_DROP  = 2'd1,
    FUNC_MERGE = 2'd2,
    FUNC_CLEAR = 2'd3
  } rssd_func_e;

  typedef enum logic [1:0] {
    STAT_OK         = 2'd0,
    STAT_DROP_EMPTY = 2'd1,
    STAT_SAT        = 2'd2
  } rssd_status_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_DX,
    ST_DIV_Q,
    ST_WAIT_Q,
    ST_MEAN,
    ST_RESID,
    ST_MUL_P,
    ST_WAIT_P,
    ST_SUM,
    ST_M_DELTA,
    ST_M_MUL_U,
    ST_M_WAIT_MU,
    ST_M_WAIT_DU,
    ST_M_MEAN,
    ST_M_WAIT_SQ,
    ST_M_WAIT_PC,
    ST_M_WAIT_K,
    ST_M_WAIT_TK,
    ST_M_WAIT_TR,
    ST_M_WAIT_DR,
    ST_M_TERM,
    ST_M_SUM1,
    ST_M_SUM2,
    ST_FINISH
  } rssd_state_e;

  // saturating arithmetic result
  typedef struct packed {
    logic               sat;
    logic signed [63:0] val;
  } rssd_sres_t;

  typedef struct packed {
    logic         done;
    logic [127:0] prod;
  } rssd_mul_res_t;

  typedef struct packed {
    logic        done;
    logic        over;  // quotient did not fit 64 bits, quo is all ones
    logic [63:0] quo;
  } rssd_div_res_t;

endpackage

// File: hw/rtl/rssd_mul.sv
// ----------------------------------------------------------------------------
// rssd_mul: iterative 64x64 unsigned multiplier
// One 32x32 multiplier, four partial products accumulated into 128 bits.
// ----------------------------------------------------------------------------
module rssd_mul (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [63:0]             a_i,
  input  logic [63:0]             b_i,
  output rssd_pkg::rssd_mul_res_t res_o
);
  import rssd_pkg::*;

  logic [63:0]  a_q, b_q, pp_q;
  logic [1:0]   sh_q, sh_sel;
  logic [127:0] acc_q;
  logic [2:0]   step_q;
  logic         busy_q, pp_vld_q, done_q;
  logic [31:0]  op_a, op_b;

  // partial product order: a0*b0, a0*b1, a1*b0, a1*b1
  always_comb begin
    case (step_q[1:0])
      2'd0: begin
        op_a = a_q[31:0];  op_b = b_q[31:0];  sh_sel = 2'd0;
      end
      2'd1: begin
        op_a = a_q[31:0];  op_b = b_q[63:32]; sh_sel = 2'd1;
      end
      2'd2: begin
        op_a = a_q[63:32]; op_b = b_q[31:0];  sh_sel = 2'd1;
      end
      default: begin
        op_a = a_q[63:32]; op_b = b_q[63:32]; sh_sel = 2'd2;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q   <= 1'b0;
      step_q   <= '0;
      pp_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else if (start_i) begin
      busy_q   <= 1'b1;
      step_q   <= '0;
      pp_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else if (busy_q) begin
      step_q   <= step_q + 3'd1;
      pp_vld_q <= !step_q[2];
      if (step_q[2]) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end else begin
        done_q <= 1'b0;
      end
    end else begin
      pp_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q   <= a_i;
      b_q   <= b_i;
      acc_q <= '0;
    end else if (busy_q) begin
      if (!step_q[2]) begin
        pp_q <= {32'b0, op_a} * {32'b0, op_b};
        sh_q <= sh_sel;
      end
      if (pp_vld_q) begin
        acc_q <= acc_q + ({64'b0, pp_q} << {sh_q, 5'b0});
      end
    end
  end

  assign res_o.done = done_q;
  assign res_o.prod = acc_q;

endmodule

// File: hw/rtl/rssd_div.sv
// ----------------------------------------------------------------------------
// rssd_div: restoring divider, 128-bit dividend by a narrow divisor
// One quotient bit per cycle; 64 steps when the upper half is zero, else 128.
// ----------------------------------------------------------------------------
module rssd_div #(
  parameter int DEN_WIDTH = rssd_pkg::RSSD_COUNT_WIDTH + 1
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [127:0]            num_i,
  input  logic [DEN_WIDTH-1:0]    den_i,
  output rssd_pkg::rssd_div_res_t res_o,
  output logic [DEN_WIDTH-1:0]    rem_o
);
  import rssd_pkg::*;

  localparam logic [RSSD_DIV_IDX_W-1:0] IDX_HALF = RSSD_DIV_IDX_W'(63);
  localparam logic [RSSD_DIV_IDX_W-1:0] IDX_FULL = RSSD_DIV_IDX_W'(127);

  logic [127:0]               num_q;
  logic [DEN_WIDTH-1:0]       den_q, r_q, r_d;
  logic [63:0]                q_q;
  logic                       over_q, busy_q, done_q, ge;
  logic [RSSD_DIV_IDX_W-1:0]  idx_q;
  logic [DEN_WIDTH:0]         trial, diff;

  assign trial = {r_q, num_q[127]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};
  assign r_d   = ge ? diff[DEN_WIDTH-1:0] : trial[DEN_WIDTH-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
    end else if (busy_q && idx_q == '0) begin
      busy_q <= 1'b0;
      done_q <= 1'b1;
    end else begin
      done_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      // leading zero half contributes nothing: skip it
      if (num_i[127:64] == '0) begin
        num_q <= {num_i[63:0], 64'b0};
        idx_q <= IDX_HALF;
      end else begin
        num_q <= num_i;
        idx_q <= IDX_FULL;
      end
      den_q  <= den_i;
      r_q    <= '0;
      q_q    <= '0;
      over_q <= 1'b0;
    end else if (busy_q) begin
      num_q <= {num_q[126:0], 1'b0};
      r_q   <= r_d;
      q_q   <= {q_q[62:0], ge};
      if (ge && idx_q[RSSD_DIV_IDX_W-1]) begin
        over_q <= 1'b1;
      end
      idx_q <= idx_q - RSSD_DIV_IDX_W'(1);
    end
  end

  assign res_o.done = done_q;
  assign res_o.over = over_q;
  assign res_o.quo  = over_q ? '1 : q_q;
  assign rem_o      = r_q;

endmodule

// File: hw/rtl/running_sum_sq_deviation.sv
// ----------------------------------------------------------------------------
// running_sum_sq_deviation: online count, mean and sum of squared deviations
// Welford add/drop, Chan merge and clear on a fixed-point running aggregate.
// ----------------------------------------------------------------------------
// Each input beat carries one operation in tuser: add a Q16.16 sample, drop a
// sample (sliding window), merge a partial aggregate (count, Q32.32 mean,
// Q47.16 sum of squared deviations) or clear. Every beat yields exactly one
// output beat with the count and the sum after the operation (a negative sum
// reads as zero), a has_value flag and a status code: ok, drop on an empty set,
// or saturated. The block handles one beat at a time; s_axis_tready is high
// only while the sequencer is idle, and a finished result sits in an output
// register so the next beat can be taken while it waits. Timing is set by the
// one shared restoring divider (one quotient bit per cycle, running over the low
// half only when the upper half of the dividend is zero) and the shared 32x32
// multiplier, which builds each 64x64 product from 32-bit partial products. An
// add or drop runs one divide and one product, a merge three divides and five
// products, and clear and the trivial cases use neither unit.
module running_sum_sq_deviation #(
  parameter int COUNT_WIDTH = rssd_pkg::RSSD_COUNT_WIDTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [31:0] sample, [63:32] part_count, [127:64] part_mean, [190:128] part_sxx
  input  logic [191:0] s_axis_tdata,
  // [1:0] func
  input  logic [1:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [31:0] sample_count, [94:32] sxx, [95] has_value, [97:96] status
  output logic [103:0] m_axis_tdata
);
  import rssd_pkg::*;

  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  // --------------------------------------------------------------------------
  // saturating helpers
  // --------------------------------------------------------------------------
  function automatic rssd_sres_t sat_addsub(logic signed [63:0] a,
                                            logic signed [63:0] b, logic sub);
    logic signed [64:0] ea, eb, s;
    rssd_sres_t r;
    ea = {a[63], a};
    eb = {b[63], b};
    s  = sub ? ea - eb : ea + eb;
    if (s[64] != s[63]) begin
      r.sat = 1'b1;
      r.val = s[64] ? S64_MIN : S64_MAX;
    end else begin
      r.sat = 1'b0;
      r.val = s[63:0];
    end
    return r;
  endfunction

  // magnitude plus sign to signed, clamped
  function automatic rssd_sres_t signed_of(logic neg, logic [63:0] m);
    rssd_sres_t r;
    if (neg) begin
      r.sat = m[63] && (m[62:0] != '0);
      r.val = r.sat ? S64_MIN : 64'(64'd0 - m);  // -2^63 maps onto itself
    end else begin
      r.sat = m[63];
      r.val = m[63] ? S64_MAX : m;
    end
    return r;
  endfunction

  function automatic logic [63:0] mag(logic signed [63:0] a);
    return a[63] ? 64'(64'd0 - a) : a;
  endfunction

  // --------------------------------------------------------------------------
  // registers
  // --------------------------------------------------------------------------
  rssd_state_e             state_q, state_d;
  rssd_func_e              fn_q, fn_d;
  logic signed [63:0]      x_q, x_d, pm_q, pm_d, ps_q, ps_d;
  logic [31:0]             pc_q, pc_d;
  logic [COUNT_WIDTH-1:0]  cnt_q, cnt_d, pcc_q, pcc_d;
  logic [COUNT_WIDTH:0]    tot_q, tot_d, rem_q, rem_d;
  logic signed [63:0]      mean_q, mean_d, sum_q, sum_d;
  logic signed [63:0]      dx_q, dx_d, tmp_q, tmp_d, aux_q, aux_d;
  logic [63:0]             t_q, t_d;
  logic                    sat_q, sat_d, err_q, err_d;

  logic                    out_valid_q, out_valid_d, out_load;
  logic [31:0]             out_cnt_q;
  logic [62:0]             out_sxx_q;
  logic                    out_has_q;
  rssd_status_e            out_status_q, status;

  // shared units
  logic                    mul_start, div_start;
  logic [63:0]             mul_a, mul_b;
  logic [127:0]            div_num;
  logic [COUNT_WIDTH:0]    div_den, div_rem;
  rssd_mul_res_t           mul_res;
  rssd_div_res_t           div_res;

  logic signed [63:0]      add_a, add_b;
  logic                    add_sub, add_use;
  rssd_sres_t              add_res;
  logic                    so_neg, so_use;
  logic [63:0]             so_mag;
  rssd_sres_t              so_res;
  logic                    sat_set, sat_clr;

  logic [RSSD_COUNT_WIDTH_MAX-1:0] pc_ext, cnt_ext;
  logic                    pc_over;
  logic [COUNT_WIDTH-1:0]  pcc;
  logic [COUNT_WIDTH:0]    tot_sum;
  logic [63:0]             mag_dx, mag_tmp;
  logic                    prod_ovf;  // product needs more than Q47.16

  rssd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .res_o   (mul_res)
  );

  rssd_div #(
    .DEN_WIDTH (COUNT_WIDTH + 1)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .res_o   (div_res),
    .rem_o   (div_rem)
  );

  // one saturating adder and one sign-apply stage, muxed per state
  assign add_res  = sat_addsub(add_a, add_b, add_sub);
  assign so_res   = signed_of(so_neg, so_mag);

  assign mag_dx   = mag(dx_q);
  assign mag_tmp  = mag(tmp_q);
  assign prod_ovf = mul_res.prod[127:112] != '0;

  // partial count clamp for narrow count widths
  assign pc_ext   = RSSD_COUNT_WIDTH_MAX'(pc_q);
  assign pc_over  = (pc_ext >> COUNT_WIDTH) != '0;
  assign pcc      = pc_over ? CNT_MAX : pc_ext[COUNT_WIDTH-1:0];
  assign tot_sum  = {1'b0, pcc} + {1'b0, cnt_q};
  assign cnt_ext  = RSSD_COUNT_WIDTH_MAX'(cnt_q);

  assign s_axis_tready = (state_q == ST_IDLE);

  // --------------------------------------------------------------------------
  // sequencer
  // --------------------------------------------------------------------------
  always_comb begin
    state_d   = state_q;
    fn_d      = fn_q;
    x_d       = x_q;
    pm_d      = pm_q;
    ps_d      = ps_q;
    pc_d      = pc_q;
    cnt_d     = cnt_q;
    pcc_d     = pcc_q;
    tot_d     = tot_q;
    rem_d     = rem_q;
    mean_d    = mean_q;
    sum_d     = sum_q;
    dx_d      = dx_q;
    tmp_d     = tmp_q;
    aux_d     = aux_q;
    t_d       = t_q;
    err_d     = err_q;
    mul_start = 1'b0;
    mul_a     = mag_dx;
    mul_b     = mag_dx;
    div_start = 1'b0;
    div_num   = mul_res.prod;
    div_den   = tot_q;
    add_a     = mean_q;
    add_b     = tmp_q;
    add_sub   = 1'b0;
    add_use   = 1'b0;
    so_neg    = 1'b0;
    so_mag    = div_res.quo;
    so_use    = 1'b0;
    sat_set   = 1'b0;
    sat_clr   = 1'b0;
    out_load  = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          fn_d    = rssd_func_e'(s_axis_tuser);
          // Q16.16 sample widened to Q32.32
          x_d     = {{16{s_axis_tdata[31]}}, s_axis_tdata[31:0], 16'b0};
          pc_d    = s_axis_tdata[63:32];
          pm_d    = s_axis_tdata[127:64];
          ps_d    = {1'b0, s_axis_tdata[190:128]};
          err_d   = 1'b0;
          sat_clr = 1'b1;
          state_d = ST_DISPATCH;
        end
      end

      ST_DISPATCH: begin
        case (fn_q)
          FUNC_ADD: begin
            if (cnt_q == CNT_MAX) begin
              sat_set = 1'b1;  // full count: sample ignored
              state_d = ST_FINISH;
            end else begin
              cnt_d   = cnt_q + COUNT_WIDTH'(1);
              state_d = ST_DX;
            end
          end
          FUNC_DROP: begin
            if (cnt_q == '0) begin
              err_d   = 1'b1;
              state_d = ST_FINISH;
            end else if (cnt_q == COUNT_WIDTH'(1)) begin
              cnt_d   = '0;  // last sample gone
              mean_d  = '0;
              sum_d   = '0;
              state_d = ST_FINISH;
            end else begin
              cnt_d   = cnt_q - COUNT_WIDTH'(1);
              state_d = ST_DX;
            end
          end
          FUNC_MERGE: begin
            sat_set = pc_over;
            pcc_d   = pcc;
            tot_d   = tot_sum;
            // two empty sets: nothing to do
            state_d = (tot_sum == '0) ? ST_FINISH : ST_M_DELTA;
          end
          default: begin  // clear
            cnt_d   = '0;
            mean_d  = '0;
            sum_d   = '0;
            state_d = ST_FINISH;
          end
        endcase
      end

      // ---- add / drop ----
      ST_DX: begin
        add_a   = x_q;
        add_b   = mean_q;
        add_sub = 1'b1;
        add_use = 1'b1;
        dx_d    = add_res.val;
        state_d = ST_DIV_Q;
      end

      ST_DIV_Q: begin
        div_start = 1'b1;
        div_num   = {64'b0, mag_dx};
        div_den   = {1'b0, cnt_q};
        state_d   = ST_WAIT_Q;
      end

      ST_WAIT_Q: begin
        if (div_res.done) begin
          so_neg  = dx_q[63];
          so_mag  = div_res.quo;
          so_use  = 1'b1;
          sat_set = div_res.over;
          tmp_d   = so_res.val;
          state_d = ST_MEAN;
        end
      end

      ST_MEAN: begin
        add_a   = mean_q;
        add_b   = tmp_q;
        add_sub = (fn_q == FUNC_DROP);
        add_use = 1'b1;
        mean_d  = add_res.val;
        state_d = ST_RESID;
      end

      ST_RESID: begin
        add_a   = x_q;
        add_b   = mean_q;
        add_sub = 1'b1;
        add_use = 1'b1;
        tmp_d   = add_res.val;
        state_d = ST_MUL_P;
      end

      ST_MUL_P: begin
        mul_start = 1'b1;
        mul_a     = mag_dx;
        mul_b     = mag_tmp;
        state_d   = ST_WAIT_P;
      end

      ST_WAIT_P: begin
        if (mul_res.done) begin
          so_neg  = dx_q[63] ^ tmp_q[63];
          so_mag  = prod_ovf ? '1 : mul_res.prod[111:48];
          so_use  = 1'b1;
          sat_set = prod_ovf;
          tmp_d   = so_res.val;
          state_d = ST_SUM;
        end
      end

      ST_SUM: begin
        add_a   = sum_q;
        add_b   = tmp_q;
        add_sub = (fn_q == FUNC_DROP);
        add_use = 1'b1;
        sum_d   = add_res.val;
        state_d = ST_FINISH;
      end

      // ---- merge ----
      ST_M_DELTA: begin
        add_a   = mean_q;
        add_b   = pm_q;
        add_sub = 1'b1;
        add_use = 1'b1;
        dx_d    = add_res.val;
        state_d = ST_M_MUL_U;
      end

      ST_M_MUL_U: begin
        mul_start = 1'b1;
        mul_a     = mag_dx;
        mul_b     = 64'(cnt_q);
        state_d   = ST_M_WAIT_MU;
      end

      ST_M_WAIT_MU: begin
        if (mul_res.done) begin
          div_start = 1'b1;  // |delta|*count / total
          state_d   = ST_M_WAIT_DU;
        end
      end

      ST_M_WAIT_DU: begin
        if (div_res.done) begin
          so_neg  = dx_q[63];
          so_mag  = div_res.quo;
          so_use  = 1'b1;
          sat_set = div_res.over;
          tmp_d   = so_res.val;
          state_d = ST_M_MEAN;
        end
      end

      ST_M_MEAN: begin
        add_a     = pm_q;
        add_b     = tmp_q;
        add_use   = 1'b1;
        mean_d    = add_res.val;
        mul_start = 1'b1;  // delta squared
        mul_a     = mag_dx;
        mul_b     = mag_dx;
        state_d   = ST_M_WAIT_SQ;
      end

      ST_M_WAIT_SQ: begin
        if (mul_res.done) begin
          t_d       = prod_ovf ? '1 : mul_res.prod[111:48];
          sat_set   = prod_ovf;
          mul_start = 1'b1;  // part count times own count
          mul_a     = 64'(pcc_q);
          mul_b     = 64'(cnt_q);
          state_d   = ST_M_WAIT_PC;
        end
      end

      ST_M_WAIT_PC: begin
        if (mul_res.done) begin
          div_start = 1'b1;
          state_d   = ST_M_WAIT_K;
        end
      end

      ST_M_WAIT_K: begin
        if (div_res.done) begin
          aux_d     = div_res.quo;
          rem_d     = div_rem;
          sat_set   = div_res.over;
          mul_start = 1'b1;  // t * k
          mul_a     = t_q;
          mul_b     = div_res.quo;
          state_d   = ST_M_WAIT_TK;
        end
      end

      ST_M_WAIT_TK: begin
        if (mul_res.done) begin
          so_neg    = 1'b0;
          so_mag    = (mul_res.prod[127:64] != '0) ? '1 : mul_res.prod[63:0];
          so_use    = 1'b1;
          sat_set   = mul_res.prod[127:64] != '0;
          tmp_d     = so_res.val;
          mul_start = 1'b1;  // t * remainder, fractional part of the weight
          mul_a     = t_q;
          mul_b     = 64'(rem_q);
          state_d   = ST_M_WAIT_TR;
        end
      end

      ST_M_WAIT_TR: begin
        if (mul_res.done) begin
          div_start = 1'b1;
          state_d   = ST_M_WAIT_DR;
        end
      end

      ST_M_WAIT_DR: begin
        if (div_res.done) begin
          so_neg  = 1'b0;
          so_mag  = div_res.quo;
          so_use  = 1'b1;
          sat_set = div_res.over;
          aux_d   = so_res.val;
          state_d = ST_M_TERM;
        end
      end

      ST_M_TERM: begin
        add_a   = tmp_q;
        add_b   = aux_q;
        add_use = 1'b1;
        tmp_d   = add_res.val;
        state_d = ST_M_SUM1;
      end

      ST_M_SUM1: begin
        add_a   = sum_q;
        add_b   = ps_q;
        add_use = 1'b1;
        sum_d   = add_res.val;
        state_d = ST_M_SUM2;
      end

      ST_M_SUM2: begin
        add_a   = sum_q;
        add_b   = tmp_q;
        add_use = 1'b1;
        sum_d   = add_res.val;
        // total count clamps; the formula above used the true total
        cnt_d   = tot_q[COUNT_WIDTH] ? CNT_MAX : tot_q[COUNT_WIDTH-1:0];
        sat_set = tot_q[COUNT_WIDTH];
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        if (!out_valid_q || m_axis_tready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase

    sat_d = (sat_q & ~sat_clr) | (add_use & add_res.sat) | (so_use & so_res.sat) | sat_set;
  end

  assign out_valid_d = out_load | (out_valid_q & ~m_axis_tready);

  always_comb begin
    if (err_q) begin
      status = STAT_DROP_EMPTY;
    end else if (sat_q) begin
      status = STAT_SAT;
    end else begin
      status = STAT_OK;
    end
  end

  // control and architectural state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      mean_q      <= '0;
      sum_q       <= '0;
      sat_q       <= 1'b0;
      err_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      mean_q      <= mean_d;
      sum_q       <= sum_d;
      sat_q       <= sat_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  // operands and scratch
  always_ff @(posedge clk_i) begin
    fn_q  <= fn_d;
    x_q   <= x_d;
    pm_q  <= pm_d;
    ps_q  <= ps_d;
    pc_q  <= pc_d;
    pcc_q <= pcc_d;
    tot_q <= tot_d;
    rem_q <= rem_d;
    dx_q  <= dx_d;
    tmp_q <= tmp_d;
    aux_q <= aux_d;
    t_q   <= t_d;
    if (out_load) begin
      out_cnt_q    <= cnt_ext[31:0];
      out_sxx_q    <= sum_q[63] ? '0 : sum_q[62:0];
      out_has_q    <= cnt_q != '0;
      out_status_q <= status;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'b0, out_status_q, out_has_q, out_sxx_q, out_cnt_q};

  // --------------------------------------------------------------------------
  // assertions
  // --------------------------------------------------------------------------
  a_units_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mul_start && div_start))
    else $error("multiplier and divider started together");

  a_result_from_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_FINISH))
    else $error("result beat raised outside finish");

  a_count_held_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |=> $stable(cnt_q))
    else $error("count changed while idle");

  a_err_only_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |-> (fn_q == FUNC_DROP))
    else $error("empty-set error on an operation other than drop");

endmodule
